### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion helpers, same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Types and constants for the segment track table.
// ----------------------------------------------------------------------------
package stt_pkg;
  localparam int ENTRIES = 16;
  localparam int CW = 16;
  localparam int IW = $clog2(ENTRIES);
  localparam int NW = $clog2(ENTRIES + 1);
  localparam int ROWW = 4 * CW + 8;

  localparam logic [1:0] REG_TOL = 2'd0;
  localparam logic [1:0] REG_GAMMA = 2'd1;
  localparam logic [1:0] REG_MAXC = 2'd2;

  localparam logic [1:0] ST_MATCH = 2'd0;
  localparam logic [1:0] ST_APPEND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_CLEAR = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_TEST, S_EVAL, S_WR, S_OUT
  } state_t;
endpackage

### rtl/stt_if.sv
// ----------------------------------------------------------------------------
// stt_in_if / stt_out_if / stt_cfg_if
// Valid-ready channels of the segment track table.
// ----------------------------------------------------------------------------
interface stt_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic signed [15:0] x0, y0, x1, y1, x2, y2, x3, y3;
  modport source (output valid, cmd, x0, y0, x1, y1, x2, y2, x3, y3, input ready);
  modport sink (input valid, cmd, x0, y0, x1, y1, x2, y2, x3, y3, output ready);
endinterface

interface stt_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [3:0] slot;
  logic [7:0] conf;
  logic signed [15:0] end_a_x, end_a_y, end_b_x, end_b_y;
  logic [4:0] live;
  logic [4:0] removed;
  modport source (output valid, status, slot, conf, end_a_x, end_a_y, end_b_x, end_b_y,
                  live, removed, input ready);
  modport sink (input valid, status, slot, conf, end_a_x, end_a_y, end_b_x, end_b_y,
                live, removed, output ready);
endinterface

interface stt_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/stt_ram.sv
// ----------------------------------------------------------------------------
// stt_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/segment_track_table.sv
// ----------------------------------------------------------------------------
// segment_track_table
// Ordered table of tracked segments with smoothing and area clearing.
// Each request steps through S_RD, S_TEST and S_EVAL for every live entry scanned, then S_WR and S_OUT.
// A new request is accepted only in S_IDLE, once the previous result has been taken.
// A clear request scans every live entry; a track request stops at a match.
// Reset (rst_n low, synchronous) empties the table and loads default registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module segment_track_table
  import stt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  stt_in_if.sink     in_ch,
  stt_out_if.source  out_ch,
  stt_cfg_if.sink    cfg_ch
);
  state_t state_r, state_nxt;
  logic [14:0] tol_r;
  logic [15:0] gamma_r;
  logic [7:0]  maxc_r;
  logic [NW-1:0] occ_r, occ_nxt;
  logic [NW-1:0] k_r, k_nxt;
  logic [NW-1:0] w_r, w_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic cmd_r;
  logic signed [CW-1:0] px_r [4];
  logic signed [CW-1:0] py_r [4];
  logic found_r, found_nxt;

  logic we;
  logic [IW-1:0] waddr, raddr;
  logic [ROWW-1:0] wdata, rdata;

  logic signed [CW-1:0] eax, eay, ebx, eby;
  logic [7:0] econf;
  assign {eax, eay, ebx, eby, econf} = rdata;

  // stage registers of the entry test
  logic [33:0] d_r [4];
  logic        in_r [2];
  logic signed [CW-1:0] rax_r, ray_r, rbx_r, rby_r;
  logic [7:0] rconf_r;

  // result registers
  logic [1:0] o_status_r;
  logic [3:0] o_slot_r;
  logic [7:0] o_conf_r;
  logic signed [CW-1:0] o_ax_r, o_ay_r, o_bx_r, o_by_r;
  logic out_valid_r;

  // blended row registers
  logic signed [CW-1:0] nax_r, nay_r, nbx_r, nby_r;
  logic [7:0] nconf_r;

  assign cfg_ch.ready = (state_r == S_IDLE);
  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;

  stt_ram #(.WIDTH(ROWW), .DEPTH(ENTRIES)) u_rows (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [33:0] sqd(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                                       logic signed [CW-1:0] c, logic signed [CW-1:0] d);
    logic signed [CW:0] dx, dy;
    logic [CW:0] mx, my;
    begin
      dx = {a[CW-1], a} - {c[CW-1], c};
      dy = {b[CW-1], b} - {d[CW-1], d};
      mx = dx[CW] ? (CW+1)'(-dx) : dx;
      my = dy[CW] ? (CW+1)'(-dy) : dy;
      sqd = 34'(mx * mx) + 34'(my * my);
    end
  endfunction

  // even-odd crossing test with exact cross-multiplication
  function automatic logic pin(logic signed [CW-1:0] tx, logic signed [CW-1:0] ty,
                               logic signed [CW-1:0] qx0, logic signed [CW-1:0] qy0,
                               logic signed [CW-1:0] qx1, logic signed [CW-1:0] qy1,
                               logic signed [CW-1:0] qx2, logic signed [CW-1:0] qy2,
                               logic signed [CW-1:0] qx3, logic signed [CW-1:0] qy3);
    logic signed [CW-1:0] vx [4];
    logic signed [CW-1:0] vy [4];
    logic signed [CW:0] den, ax, bx, by;
    logic signed [2*CW+1:0] lhs, rhs;
    logic res;
    int j;
    begin
      vx[0] = qx0; vx[1] = qx1; vx[2] = qx2; vx[3] = qx3;
      vy[0] = qy0; vy[1] = qy1; vy[2] = qy2; vy[3] = qy3;
      res = 1'b0;
      for (int i = 0; i < 4; i++) begin
        j = (i == 0) ? 3 : i - 1;
        if ((vy[i] > ty) != (vy[j] > ty)) begin
          den = {vy[j][CW-1], vy[j]} - {vy[i][CW-1], vy[i]};
          ax = {tx[CW-1], tx} - {vx[i][CW-1], vx[i]};
          bx = {vx[j][CW-1], vx[j]} - {vx[i][CW-1], vx[i]};
          by = {ty[CW-1], ty} - {vy[i][CW-1], vy[i]};
          lhs = ax * den;
          rhs = bx * by;
          if (den > 0 ? (lhs < rhs) : (lhs > rhs)) begin
            res = !res;
          end
        end
      end
      pin = res;
    end
  endfunction

  function automatic logic signed [CW-1:0] blend(logic signed [CW-1:0] o,
                                                  logic signed [CW-1:0] b,
                                                  logic [16:0] g);
    logic signed [35:0] v;
    begin
      v = 36'(o * $signed({1'b0, g})) + 36'(b * $signed(17'd32768 - g)) + 36'sd16384;
      blend = CW'(v >>> 15);
    end
  endfunction

  logic [16:0] gsat;
  logic [33:0] tol2;
  logic hit;
  logic [1:0] best;
  assign gsat = (gamma_r > 16'd32768) ? 17'd32768 : {1'b0, gamma_r};
  assign tol2 = 34'(tol_r * tol_r);
  assign hit = (d_r[0] < tol2 && d_r[3] < tol2) || (d_r[2] < tol2 && d_r[1] < tol2);

  always_comb begin
    best = 2'd0;
    if (d_r[1] < d_r[0]) best = 2'd1;
    if (d_r[2] < d_r[best]) best = 2'd2;
    if (d_r[3] < d_r[best]) best = 2'd3;
  end

  logic dec;
  logic [7:0] cconf;
  assign dec = in_r[0] && in_r[1] && (rconf_r != 8'd0);
  assign cconf = dec ? rconf_r - 8'd1 : rconf_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r;
    w_nxt = w_r;
    rem_nxt = rem_r;
    occ_nxt = occ_r;
    found_nxt = found_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          k_nxt = '0;
          w_nxt = '0;
          rem_nxt = '0;
          found_nxt = 1'b0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (k_r >= occ_r) begin
          state_nxt = S_WR;
        end else begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: state_nxt = S_EVAL;
      S_EVAL: begin
        if (!cmd_r) begin
          if (hit) begin
            found_nxt = 1'b1;
            state_nxt = S_WR;
          end else begin
            k_nxt = k_r + 1'b1;
            state_nxt = S_RD;
          end
        end else begin
          if (cconf == 8'd0) begin
            rem_nxt = rem_r + 1'b1;
          end else begin
            w_nxt = w_r + 1'b1;
          end
          k_nxt = k_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_WR: begin
        if (cmd_r) begin
          occ_nxt = w_r;
        end else if (!found_r && occ_r < NW'(ENTRIES)) begin
          occ_nxt = occ_r + 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    raddr = k_r[IW-1:0];
    we = 1'b0;
    waddr = k_r[IW-1:0];
    wdata = {nax_r, nay_r, nbx_r, nby_r, nconf_r};
    case (state_r)
      S_EVAL: begin
        if (cmd_r && cconf != 8'd0) begin
          we = 1'b1;
          waddr = w_r[IW-1:0];
          wdata = {rax_r, ray_r, rbx_r, rby_r, cconf};
        end
      end
      S_WR: begin
        if (!cmd_r && found_r) begin
          we = 1'b1;
        end else if (!cmd_r && occ_r < NW'(ENTRIES)) begin
          we = 1'b1;
          waddr = occ_r[IW-1:0];
          wdata = {px_r[0], py_r[0], px_r[1], py_r[1], 8'd1};
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tol_r <= 15'd512;
      gamma_r <= 16'd29491;
      maxc_r <= 8'd100;
      occ_r <= '0;
      k_r <= '0;
      w_r <= '0;
      rem_r <= '0;
      found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r <= occ_nxt;
      k_r <= k_nxt;
      w_r <= w_nxt;
      rem_r <= rem_nxt;
      found_r <= found_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_TOL: tol_r <= cfg_ch.data[14:0];
          REG_GAMMA: gamma_r <= cfg_ch.data;
          REG_MAXC: maxc_r <= cfg_ch.data[7:0];
          default: ;
        endcase
      end
      if (state_r == S_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid && in_ch.ready) begin
      cmd_r <= in_ch.cmd;
      px_r[0] <= in_ch.x0; py_r[0] <= in_ch.y0;
      px_r[1] <= in_ch.x1; py_r[1] <= in_ch.y1;
      px_r[2] <= in_ch.x2; py_r[2] <= in_ch.y2;
      px_r[3] <= in_ch.x3; py_r[3] <= in_ch.y3;
    end
    if (state_r == S_TEST) begin
      rax_r <= eax; ray_r <= eay; rbx_r <= ebx; rby_r <= eby;
      rconf_r <= econf;
      d_r[0] <= sqd(eax, eay, px_r[0], py_r[0]);
      d_r[1] <= sqd(eax, eay, px_r[1], py_r[1]);
      d_r[2] <= sqd(ebx, eby, px_r[0], py_r[0]);
      d_r[3] <= sqd(ebx, eby, px_r[1], py_r[1]);
      in_r[0] <= pin(eax, eay, px_r[0], py_r[0], px_r[1], py_r[1],
                     px_r[2], py_r[2], px_r[3], py_r[3]);
      in_r[1] <= pin(ebx, eby, px_r[0], py_r[0], px_r[1], py_r[1],
                     px_r[2], py_r[2], px_r[3], py_r[3]);
    end
    if (state_r == S_EVAL && !cmd_r && hit) begin
      if (best == 2'd1 || best == 2'd2) begin
        nax_r <= blend(rax_r, px_r[1], gsat);
        nay_r <= blend(ray_r, py_r[1], gsat);
        nbx_r <= blend(rbx_r, px_r[0], gsat);
        nby_r <= blend(rby_r, py_r[0], gsat);
      end else begin
        nax_r <= blend(rax_r, px_r[0], gsat);
        nay_r <= blend(ray_r, py_r[0], gsat);
        nbx_r <= blend(rbx_r, px_r[1], gsat);
        nby_r <= blend(rby_r, py_r[1], gsat);
      end
      nconf_r <= (rconf_r < maxc_r) ? rconf_r + 8'd1 : rconf_r;
    end
    if (state_r == S_WR) begin
      if (cmd_r) begin
        o_status_r <= ST_CLEAR; o_slot_r <= '0; o_conf_r <= '0;
        o_ax_r <= '0; o_ay_r <= '0; o_bx_r <= '0; o_by_r <= '0;
      end else if (found_r) begin
        o_status_r <= ST_MATCH; o_slot_r <= 4'(k_r); o_conf_r <= nconf_r;
        o_ax_r <= nax_r; o_ay_r <= nay_r; o_bx_r <= nbx_r; o_by_r <= nby_r;
      end else if (occ_r < NW'(ENTRIES)) begin
        o_status_r <= ST_APPEND; o_slot_r <= 4'(occ_r); o_conf_r <= 8'd1;
        o_ax_r <= px_r[0]; o_ay_r <= py_r[0]; o_bx_r <= px_r[1]; o_by_r <= py_r[1];
      end else begin
        o_status_r <= ST_FULL; o_slot_r <= '0; o_conf_r <= '0;
        o_ax_r <= px_r[0]; o_ay_r <= py_r[0]; o_bx_r <= px_r[1]; o_by_r <= py_r[1];
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = o_status_r;
  assign out_ch.slot = o_slot_r;
  assign out_ch.conf = o_conf_r;
  assign out_ch.end_a_x = o_ax_r;
  assign out_ch.end_a_y = o_ay_r;
  assign out_ch.end_b_x = o_bx_r;
  assign out_ch.end_b_y = o_by_r;
  assign out_ch.live = 5'(occ_r);
  assign out_ch.removed = cmd_r ? 5'(rem_r) : 5'd0;

  `ASSERT_IMPL(a_occ_range, clk, rst_n, 1'b1, occ_r <= NW'(ENTRIES), "occupancy overflow")
  `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_ch.ready,
               "input ready while busy")
  `ASSERT_NEXT(a_out_after, clk, rst_n, state_r == S_OUT, out_ch.valid,
               "result not shown after finish")
  `ASSERT_IMPL(a_compact, clk, rst_n, state_r != S_IDLE, w_r <= k_r, "write ahead of read")
endmodule

### tb/segment_track_table_tb.sv
// ----------------------------------------------------------------------------
// segment_track_table_tb
// Self-checking bench: drives track and clear requests and register writes,
// keeps its own model of the segment table, and compares every result.
// ----------------------------------------------------------------------------
module segment_track_table_tb;
  import stt_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN = 60;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic cmd;
    logic signed [15:0] x[4];
    logic signed [15:0] y[4];
  } seg_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot;
    logic [7:0] conf;
    logic signed [15:0] ax, ay, bx, by;
    logic [4:0] live;
    logic [4:0] removed;
  } seg_result_t;

  logic clk;
  logic rst_n;

  stt_in_if  in_ch();
  stt_out_if out_ch();
  stt_cfg_if cfg_ch();

  segment_track_table u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic signed [15:0] trk_ax[ENTRIES];
  logic signed [15:0] trk_ay[ENTRIES];
  logic signed [15:0] trk_bx[ENTRIES];
  logic signed [15:0] trk_by[ENTRIES];
  logic [7:0]         trk_conf[ENTRIES];
  int                 trk_live;
  int                 tol_reg;
  int                 gamma_reg;
  int                 maxc_reg;

  seg_result_t result_q[$];
  int          errors;
  bit          calm;
  int          quiet_cycles = 0;
  int          ready_hold = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sq_gap(longint ax, longint ay, longint bx, longint by);
    return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
  endfunction

  function automatic logic signed [15:0] smooth(longint old, longint obs, longint g);
    longint v;
    v = old * g + obs * (32768 - g) + 16384;
    return 16'(v >>> 15);
  endfunction

  function automatic bit in_quad(seg_req_t q, longint tx, longint ty);
    bit in_flag;
    int j;
    longint xi, yi, xj, yj, den, lhs, rhs;
    in_flag = 1'b0;
    for (int i = 0; i < 4; i++) begin
      j = (i == 0) ? 3 : i - 1;
      xi = q.x[i]; yi = q.y[i]; xj = q.x[j]; yj = q.y[j];
      if ((yi > ty) != (yj > ty)) begin
        den = yj - yi;
        lhs = (tx - xi) * den;
        rhs = (xj - xi) * (ty - yi);
        if (den > 0 ? lhs < rhs : lhs > rhs) in_flag = !in_flag;
      end
    end
    return in_flag;
  endfunction

  function automatic seg_result_t track_table_update(seg_req_t q);
    seg_result_t r;
    longint d[4];
    longint tol2, g;
    bit found;
    int best, w, k;
    logic signed [15:0] oax, oay, obx, oby;
    r = '0;
    found = 1'b0;
    if (q.cmd == 1'b0) begin
      tol2 = longint'(tol_reg) * tol_reg;
      g = (gamma_reg > 32768) ? 32768 : gamma_reg;
      for (k = 0; k < trk_live; k++) begin
        d[0] = sq_gap(trk_ax[k], trk_ay[k], q.x[0], q.y[0]);
        d[1] = sq_gap(trk_ax[k], trk_ay[k], q.x[1], q.y[1]);
        d[2] = sq_gap(trk_bx[k], trk_by[k], q.x[0], q.y[0]);
        d[3] = sq_gap(trk_bx[k], trk_by[k], q.x[1], q.y[1]);
        if ((d[0] < tol2 && d[3] < tol2) || (d[2] < tol2 && d[1] < tol2)) begin
          best = 0;
          for (int p = 1; p < 4; p++)
            if (d[p] < d[best]) best = p;
          if (best == 1 || best == 2) begin
            oax = q.x[1]; oay = q.y[1]; obx = q.x[0]; oby = q.y[0];
          end else begin
            oax = q.x[0]; oay = q.y[0]; obx = q.x[1]; oby = q.y[1];
          end
          trk_ax[k] = smooth(trk_ax[k], oax, g);
          trk_ay[k] = smooth(trk_ay[k], oay, g);
          trk_bx[k] = smooth(trk_bx[k], obx, g);
          trk_by[k] = smooth(trk_by[k], oby, g);
          if (trk_conf[k] < maxc_reg) trk_conf[k] = trk_conf[k] + 8'd1;
          found = 1'b1;
          break;
        end
      end
      if (!found && trk_live < ENTRIES) begin
        k = trk_live;
        trk_ax[k] = q.x[0]; trk_ay[k] = q.y[0];
        trk_bx[k] = q.x[1]; trk_by[k] = q.y[1];
        trk_conf[k] = 8'd1;
        trk_live++;
        found = 1'b1;
        r.status = ST_APPEND;
      end else if (found) begin
        r.status = ST_MATCH;
      end
      if (found) begin
        r.slot = 4'(k);
        r.conf = trk_conf[k];
        r.ax = trk_ax[k]; r.ay = trk_ay[k]; r.bx = trk_bx[k]; r.by = trk_by[k];
      end else begin
        r.status = ST_FULL;
        r.ax = q.x[0]; r.ay = q.y[0]; r.bx = q.x[1]; r.by = q.y[1];
      end
    end else begin
      r.status = ST_CLEAR;
      w = 0;
      for (k = 0; k < trk_live; k++) begin
        if (in_quad(q, trk_ax[k], trk_ay[k]) && in_quad(q, trk_bx[k], trk_by[k]))
          if (trk_conf[k] > 0) trk_conf[k] = trk_conf[k] - 8'd1;
        if (trk_conf[k] == 0) begin
          r.removed = r.removed + 5'd1;
          continue;
        end
        trk_ax[w] = trk_ax[k]; trk_ay[w] = trk_ay[k];
        trk_bx[w] = trk_bx[k]; trk_by[w] = trk_by[k];
        trk_conf[w] = trk_conf[k];
        w++;
      end
      trk_live = w;
    end
    r.live = 5'(trk_live);
    return r;
  endfunction

  function automatic seg_req_t seg(int ax, int ay, int bx, int by);
    seg_req_t q;
    q.cmd = 1'b0;
    q.x[0] = 16'(ax); q.y[0] = 16'(ay); q.x[1] = 16'(bx); q.y[1] = 16'(by);
    q.x[2] = 16'($urandom); q.y[2] = 16'($urandom);
    q.x[3] = 16'($urandom); q.y[3] = 16'($urandom);
    return q;
  endfunction

  function automatic seg_req_t quad(int xl, int yl, int xh, int yh);
    seg_req_t q;
    q.cmd = 1'b1;
    q.x[0] = 16'(xl); q.y[0] = 16'(yl); q.x[1] = 16'(xh); q.y[1] = 16'(yl);
    q.x[2] = 16'(xh); q.y[2] = 16'(yh); q.x[3] = 16'(xl); q.y[3] = 16'(yh);
    return q;
  endfunction

  function automatic int clip16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  function automatic int jitter(int j);
    return int'($urandom_range(0, 2 * j)) - j;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic send_req(seg_req_t q);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.cmd = q.cmd;
    in_ch.x0 = q.x[0]; in_ch.y0 = q.y[0];
    in_ch.x1 = q.x[1]; in_ch.y1 = q.y[1];
    in_ch.x2 = q.x[2]; in_ch.y2 = q.y[2];
    in_ch.x3 = q.x[3]; in_ch.y3 = q.y[3];
    do @(posedge clk); while (!in_ch.ready);
    result_q = {result_q, track_table_update(q)};
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic settle();
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = 16'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_TOL:   tol_reg = value & 16'h7FFF;
      REG_GAMMA: gamma_reg = value & 16'hFFFF;
      REG_MAXC:  maxc_reg = value & 8'hFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_regs(int tol, int g, int maxc);
    settle();
    write_reg(REG_TOL, tol);
    write_reg(REG_GAMMA, g);
    write_reg(REG_MAXC, maxc);
  endtask

  task automatic test_append_and_match();
    send_req(seg(100, 200, 1100, 200));
    send_req(seg(150, 250, 1050, 150));
    send_req(seg(1000, 260, 90, 210));
    send_req(seg(5000, 5000, 5000, 5000));
  endtask

  task automatic test_table_full();
    while (trk_live < ENTRIES)
      send_req(seg(-30000 + trk_live * 3000, 8000, -30000 + trk_live * 3000, 9000));
    send_req(seg(-32768, -32768, 32767, 32767));
    send_req(seg(32767, -32768, -32768, 32767));
  endtask

  task automatic test_clear_area();
    send_req(quad(-32000, 7000, 0, 10000));
    send_req(quad(-32768, -32768, 32767, 32767));
    send_req(quad(0, 0, 0, 0));
  endtask

  task automatic test_register_extremes();
    set_regs(0, 0, 1);
    send_req(seg(100, 200, 1100, 200));
    send_req(seg(100, 200, 1100, 200));
    set_regs(32767, 32768, 255);
    send_req(seg(200, 300, 900, 100));
    set_regs(512, 65535, 100);
    write_reg(REG_SPARE, 16'hFFFF);
    send_req(seg(120, 210, 1090, 190));
  endtask

  task automatic random_request(int tol);
    seg_req_t q;
    int k, j, sel, xl, yl, span;
    sel = $urandom_range(0, 99);
    j = (tol / 2 > 1) ? tol / 2 : 1;
    if (sel < 20) begin
      if (trk_live > 0 && $urandom_range(0, 1)) begin
        k = $urandom_range(0, trk_live - 1);
        xl = (trk_ax[k] < trk_bx[k]) ? trk_ax[k] : trk_bx[k];
        yl = (trk_ay[k] < trk_by[k]) ? trk_ay[k] : trk_by[k];
        span = $urandom_range(1, 3000);
        q = quad(clip16(xl - span), clip16(yl - span),
                 clip16(xl + span + int'($urandom_range(0, 4000))),
                 clip16(yl + span + int'($urandom_range(0, 4000))));
      end else if (sel < 4) begin
        q = quad(-32768, -32768, 32767, 32767);
      end else begin
        q = seg($urandom, $urandom, $urandom, $urandom);
        q.cmd = 1'b1;
      end
    end else if (sel < 75 && trk_live > 0) begin
      k = $urandom_range(0, trk_live - 1);
      q = seg(clip16(int'(trk_ax[k]) + jitter(j)),
              clip16(int'(trk_ay[k]) + jitter(j)),
              clip16(int'(trk_bx[k]) + jitter(j)),
              clip16(int'(trk_by[k]) + jitter(j)));
      if ($urandom_range(0, 1)) q = seg(q.x[1], q.y[1], q.x[0], q.y[0]);
    end else if (sel < 92) begin
      q = seg($urandom_range(0, 8192) - 4096, $urandom_range(0, 8192) - 4096,
              $urandom_range(0, 8192) - 4096, $urandom_range(0, 8192) - 4096);
    end else begin
      q = seg($urandom, $urandom, $urandom, $urandom);
    end
    send_req(q);
  endtask

  task automatic test_random_traffic();
    int tols[6]  = '{512, 0, 32767, 2000, 300, 1024};
    int gams[6]  = '{29491, 0, 32768, 65535, 16384, 1};
    int maxcs[6] = '{100, 1, 255, 3, 2, 40};
    for (int ph = 0; ph < 6; ph++) begin
      set_regs(tols[ph], gams[ph], maxcs[ph]);
      if (ph == 5) calm = 1'b1;
      repeat (300) random_request(tol_reg);
    end
  endtask

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ch.ready = 1'b0;
      ready_hold--;
    end else begin
      out_ch.ready = 1'b1;
      if (!calm && $urandom_range(0, 4) == 0) ready_hold = $urandom_range(1, 7);
    end
  end

  always @(posedge clk) begin
    seg_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (result_q.size() == 0) begin
        report("unexpected result", out_ch.status, -1);
      end else begin
        want = result_q.pop_front();
        if (out_ch.status !== want.status) report("status", out_ch.status, want.status);
        if (out_ch.slot !== want.slot) report("slot", out_ch.slot, want.slot);
        if (out_ch.conf !== want.conf) report("conf", out_ch.conf, want.conf);
        if (out_ch.end_a_x !== want.ax) report("end_a_x", out_ch.end_a_x, want.ax);
        if (out_ch.end_a_y !== want.ay) report("end_a_y", out_ch.end_a_y, want.ay);
        if (out_ch.end_b_x !== want.bx) report("end_b_x", out_ch.end_b_x, want.bx);
        if (out_ch.end_b_y !== want.by) report("end_b_y", out_ch.end_b_y, want.by);
        if (out_ch.live !== want.live) report("live", out_ch.live, want.live);
        if (out_ch.removed !== want.removed) report("removed", out_ch.removed, want.removed);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL segment_track_table");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    calm = 1'b0;
    errors = 0;
    trk_live = 0;
    tol_reg = 512;
    gamma_reg = 29491;
    maxc_reg = 100;
    in_ch.valid = 1'b0;
    in_ch.cmd = 1'b0;
    {in_ch.x0, in_ch.y0, in_ch.x1, in_ch.y1} = '0;
    {in_ch.x2, in_ch.y2, in_ch.x3, in_ch.y3} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_TOL;
    cfg_ch.data = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_append_and_match();
    test_table_full();
    test_clear_area();
    test_register_extremes();
    test_random_traffic();
    settle();
    if (errors == 0) begin
      $display("PASS segment_track_table");
    end else begin
      $display("FAIL segment_track_table");
    end
    $finish;
  end

endmodule
